[hdl/filled_circle_span_generator_assert.svh]
// Assertion macros used by the checker file.
// Each macro builds one labeled concurrent assertion, clocked on the rising edge.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define FCSG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("span generator check failed");

// Next-cycle implication.
`define FCSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("span generator check failed");

`endif

[hdl/fcsg_pkg.sv]
// ----------------------------------------------------------------------------
// fcsg_pkg
// Types and constants for the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int RADIUS_BITS_DEF = 6;
	localparam int COORD_BITS      = 10;

	// Midpoint walk constants
	localparam int DEC_INIT  = 3;   // decision start: 3 - 2r
	localparam int STEP_DIAG = 10;  // added with 4*(x-y) on a diagonal step
	localparam int STEP_AXIS = 6;   // added with 4*x on a straight step

	typedef struct packed {
		logic [7:0]  center_x;
		logic [7:0]  center_y;
		logic [5:0]  radius;
		logic [15:0] fill_color;
	} fcsg_req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] outer_start;
		logic [COORD_BITS-1:0] outer_end;
		logic [COORD_BITS-1:0] outer_row_low;
		logic [COORD_BITS-1:0] outer_row_high;
		logic [COORD_BITS-1:0] inner_start;
		logic [COORD_BITS-1:0] inner_end;
		logic [COORD_BITS-1:0] inner_row_low;
		logic [COORD_BITS-1:0] inner_row_high;
		logic [15:0]           span_color;
		logic                  last_step;
	} fcsg_span_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} fcsg_state_t;

	typedef struct packed {
		logic load;  // capture request, init walk
		logic step;  // emit current spans, advance one step
	} fcsg_cmd_t;

	typedef struct packed {
		logic last;  // current point is the final one
	} fcsg_status_t;

endpackage

[hdl/fcsg_datapath.sv]
// ----------------------------------------------------------------------------
// fcsg_datapath
// Offset and decision registers of the midpoint walk, span adders, result register.
// ----------------------------------------------------------------------------
module fcsg_datapath #(
	parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcsg_pkg::fcsg_req_t  request,
	input  fcsg_pkg::fcsg_cmd_t  cmd,
	output fcsg_pkg::fcsg_status_t status,
	output fcsg_pkg::fcsg_span_t result,
	output logic                 result_valid
);

	localparam int OW = RADIUS_BITS + 2;  // signed offset width
	localparam int DW = RADIUS_BITS + 5;  // signed decision width
	localparam int CW = fcsg_pkg::COORD_BITS;

	localparam logic signed [DW-1:0] D_INIT = DW'(fcsg_pkg::DEC_INIT);
	localparam logic signed [DW-1:0] D_DIAG = DW'(fcsg_pkg::STEP_DIAG);
	localparam logic signed [DW-1:0] D_AXIS = DW'(fcsg_pkg::STEP_AXIS);

	logic [7:0]           cx_q, cy_q;
	logic [15:0]          color_q;
	logic signed [OW-1:0] xo_q, yo_q;
	logic signed [DW-1:0] d_q;

	logic [RADIUS_BITS-1:0] r_trunc;
	logic signed [OW-1:0]   r_off;
	logic signed [OW-1:0]   xo_nx, yo_nx, diff_nx;
	logic signed [DW-1:0]   d_nx;
	logic signed [31:0]     xo_w, yo_w;
	logic [CW-1:0]          ux, uy, cx10, cy10;
	fcsg_pkg::fcsg_span_t   span_c;
	fcsg_pkg::fcsg_span_t   result_q;
	logic                   valid_q;

	// radius taken modulo 2^RADIUS_BITS
	assign r_trunc = RADIUS_BITS'(request.radius);
	assign r_off   = signed'(OW'(r_trunc));

	// one midpoint step
	always_comb begin
		xo_nx   = xo_q + OW'(1);
		yo_nx   = yo_q;
		d_nx    = d_q + (DW'(xo_nx) <<< 2) + D_AXIS;
		diff_nx = xo_nx - yo_q;
		if (d_q > 0) begin
			yo_nx   = yo_q - OW'(1);
			diff_nx = xo_nx - yo_nx;
			d_nx    = d_q + (DW'(diff_nx) <<< 2) + D_DIAG;
		end
	end

	assign status.last = (yo_q < xo_q);

	// spans, modulo 1024
	assign xo_w = 32'(xo_q);
	assign yo_w = 32'(yo_q);
	assign ux   = xo_w[CW-1:0];
	assign uy   = yo_w[CW-1:0];
	assign cx10 = CW'(cx_q);
	assign cy10 = CW'(cy_q);

	always_comb begin
		span_c.outer_start    = cx10 - ux;
		span_c.outer_end      = cx10 + ux;
		span_c.outer_row_low  = cy10 + uy;
		span_c.outer_row_high = cy10 - uy;
		span_c.inner_start    = cx10 - uy;
		span_c.inner_end      = cx10 + uy;
		span_c.inner_row_low  = cy10 + ux;
		span_c.inner_row_high = cy10 - ux;
		span_c.span_color     = color_q;
		span_c.last_step      = status.last;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= request.center_x;
			cy_q    <= request.center_y;
			color_q <= request.fill_color;
			xo_q    <= '0;
			yo_q    <= r_off;
			d_q     <= D_INIT - (DW'(r_off) <<< 1);
		end else if (cmd.step) begin
			xo_q <= xo_nx;
			yo_q <= yo_nx;
			d_q  <= d_nx;
		end
		if (cmd.step) begin
			result_q <= span_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.step;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule

[hdl/fcsg_ctrl.sv]
// ----------------------------------------------------------------------------
// fcsg_ctrl
// Controller: idle until a request is taken, then walks until the final point.
// ----------------------------------------------------------------------------
module fcsg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  fcsg_pkg::fcsg_status_t status,
	output fcsg_pkg::fcsg_cmd_t    cmd,
	output logic                   busy
);

	fcsg_pkg::fcsg_state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				if (start) state_nx = fcsg_pkg::ST_WALK;
			end
			fcsg_pkg::ST_WALK: begin
				if (status.last) state_nx = fcsg_pkg::ST_IDLE;
			end
			default: state_nx = fcsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b0;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			fcsg_pkg::ST_WALK: begin
				cmd.step = 1'b1;
				busy     = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[hdl/filled_circle_span_generator.sv]
// After start is taken the request is loaded, then each walk step registers one span beat, one beat per cycle.
// Beats: radius r gives n = about r/sqrt2 + 2 beats (at most 48 for r = 63);
//   busy stays high for the whole walk, and start is taken only while the controller is idle.
// Reset: arst_n low clears the controller to idle and drops result_valid.
// The receiver cannot stall; every beat is on result for exactly one cycle.
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Midpoint circle walk that emits four horizontal fill spans per step.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
	parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fcsg_pkg::fcsg_req_t  request,
	output logic                 result_valid,
	output fcsg_pkg::fcsg_span_t result
);

	// Controller <-> datapath
	//   load: request taken in idle; datapath sets x=0, y=r, d=3-2r.
	//   step: one point per cycle; current spans go to the result register,
	//         offsets advance one midpoint step.
	//   last: y offset has dropped below x offset, so the point being
	//         emitted is the final one; controller returns to idle.
	fcsg_pkg::fcsg_cmd_t    cmd;
	fcsg_pkg::fcsg_status_t status;

	fcsg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Spans are registered, so the last beat shows while the controller is
	// already idle and a new request can be taken in that same cycle.
	fcsg_datapath #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

[hdl/fcsg_checker.sv]
// ----------------------------------------------------------------------------
// fcsg_checker
// Port-level checks of the span generator's beat sequencing.
// ----------------------------------------------------------------------------
`include "filled_circle_span_generator_assert.svh"

module fcsg_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 result_valid,
	input fcsg_pkg::fcsg_span_t result
);

	// a taken request starts a walk
	`FCSG_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	// beats only come out of a walk
	`FCSG_ASSERT_NOW(a_beat_in_walk, clk, arst_n, result_valid, $past(busy))
	// walk ends exactly with the final beat
	`FCSG_ASSERT_NOW(a_end_last, clk, arst_n, $fell(busy), result_valid && result.last_step)
	// a non-final beat keeps the walk going
	`FCSG_ASSERT_NOW(a_mid_busy, clk, arst_n, result_valid && !result.last_step, busy)

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
